@@ rtl/core/hsvcb_pkg.sv @@
// Package for the HSV color blob centroid block.
// Field structs, register codes and sizing constants; no dependencies.
package hsvcb_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;
	localparam int CW         = 11;
	localparam int COUNT_W    = 23;
	localparam int SUM_W      = 34;
	localparam int QUO_W      = 14;
	localparam int REM_W      = 37;
	localparam int HUE_SPAN   = 180;
	localparam int COV_SCALE  = 10000;
	localparam logic [COUNT_W-1:0] COUNT_CAP = {COUNT_W{1'b1}};

	typedef enum logic [2:0] {
		REG_HUE_LOW_MAX  = 3'd0,
		REG_HUE_HIGH_MIN = 3'd1,
		REG_SAT_MIN      = 3'd2,
		REG_SAT_MAX      = 3'd3,
		REG_VAL_MIN      = 3'd4,
		REG_VAL_MAX      = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0]    blue;
		logic [7:0]    green;
		logic [7:0]    red;
		logic [CW-1:0] pos_x;
		logic [CW-1:0] pos_y;
		logic          frame_end;
	} pix_item_t;

	typedef struct packed {
		logic [CW-1:0] centroid_x;
		logic [CW-1:0] centroid_y;
		logic [13:0]   coverage;
	} res_item_t;

	typedef struct packed {
		logic [7:0] hue_low_max;
		logic [7:0] hue_high_min;
		logic [7:0] sat_min;
		logic [7:0] sat_max;
		logic [7:0] val_min;
		logic [7:0] val_max;
	} cfg_t;

	typedef struct packed {
		logic [SUM_W-1:0]   sum_x;
		logic [SUM_W-1:0]   sum_y;
		logic [COUNT_W-1:0] red_cnt;
		logic [COUNT_W-1:0] pix_cnt;
	} job_t;

endpackage

@@ rtl/core/hsvcb_front.sv @@
// Front end: config registers, HSV pipeline, red test and frame accumulators.
// Emits one division job per frame that had red pixels. Uses hsvcb_pkg.
module hsvcb_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [2:0]            cfg_index,
	input  logic [7:0]            cfg_data,
	input  logic                  push,
	output logic                  full,
	input  hsvcb_pkg::pix_item_t  pix,
	input  logic                  job_full,
	output logic                  job_push,
	output hsvcb_pkg::job_t       job
);
	import hsvcb_pkg::*;

	localparam logic [CW-1:0] XMAX = CW'(MAX_WIDTH - 1);
	localparam logic [CW-1:0] YMAX = CW'(MAX_HEIGHT - 1);

	// reciprocal tables, round(255*4096/v) and round(30*4096/d)
	logic [19:0] tab_v [256];
	logic [16:0] tab_d [256];
	for (genvar i = 0; i < 256; i++) begin : g_tab
		localparam int RV = (i == 0) ? 0 : (2 * 1044480 + i) / (2 * i + (i == 0 ? 1 : 0));
		localparam int RD = (i == 0) ? 0 : (2 * 122880 + i) / (2 * i + (i == 0 ? 1 : 0));
		assign tab_v[i] = 20'(RV);
		assign tab_d[i] = 17'(RD);
	end

	cfg_t cfg_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{hue_low_max: 8'd10, hue_high_min: 8'd170, sat_min: 8'd180,
			           sat_max: 8'd255, val_min: 8'd100, val_max: 8'd255};
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_HUE_LOW_MAX:  cfg_q.hue_low_max  <= cfg_data;
				REG_HUE_HIGH_MIN: cfg_q.hue_high_min <= cfg_data;
				REG_SAT_MIN:      cfg_q.sat_min      <= cfg_data;
				REG_SAT_MAX:      cfg_q.sat_max      <= cfg_data;
				REG_VAL_MIN:      cfg_q.val_min      <= cfg_data;
				REG_VAL_MAX:      cfg_q.val_max      <= cfg_data;
				default: ;
			endcase
		end
	end

	logic en;
	logic v_s1, v_s2, v_s3;
	logic fe_s1, fe_s2, fe_s3;
	logic [CW-1:0] x_s1, x_s2, x_s3, y_s1, y_s2, y_s3;
	logic [7:0] mx_s1, d_s1, mx_s2;
	logic signed [11:0] raw_s1;
	logic [27:0] sp_s2;
	logic signed [29:0] hp_s2;
	logic red_s3;

	// stage 1: max, min, raw hue
	logic [7:0] mx, mn, dd;
	logic signed [11:0] raw;
	always_comb begin
		mx = pix.blue;
		mn = pix.blue;
		if (pix.green > mx) mx = pix.green;
		if (pix.red > mx) mx = pix.red;
		if (pix.green < mn) mn = pix.green;
		if (pix.red < mn) mn = pix.red;
		dd = mx - mn;
		if (mx == pix.red)
			raw = $signed(12'(pix.green)) - $signed(12'(pix.blue));
		else if (mx == pix.green)
			raw = $signed(12'(pix.blue)) - $signed(12'(pix.red)) + $signed(12'({dd, 1'b0}));
		else
			raw = $signed(12'(pix.red)) - $signed(12'(pix.green)) + $signed(12'({dd, 2'b0}));
	end

	// stage 2: reciprocal multiplies
	logic [27:0] sp;
	logic signed [29:0] hp;
	always_comb begin
		sp = 28'(d_s1) * 28'(tab_v[mx_s1]);
		hp = raw_s1 * $signed({1'b0, tab_d[d_s1]});
	end

	// stage 3: round, wrap hue, red test
	logic [27:0] s_sum;
	logic [7:0] s_val;
	logic signed [29:0] hq;
	logic [8:0] h9;
	logic is_red;
	always_comb begin
		s_sum = sp_s2 + 28'd2048;
		s_val = s_sum[19:12];
		hq = (hp_s2 + 30'sd2048) >>> 12;
		h9 = hq[8:0] + ((hq < 0) ? 9'(HUE_SPAN) : 9'd0);
		is_red = (s_val >= cfg_q.sat_min) && (s_val <= cfg_q.sat_max) &&
		         (mx_s2 >= cfg_q.val_min) && (mx_s2 <= cfg_q.val_max) &&
		         ((h9 <= {1'b0, cfg_q.hue_low_max}) ||
		          ((h9 >= {1'b0, cfg_q.hue_high_min}) && (h9 <= 9'(HUE_SPAN))));
	end

	assign en   = !(v_s3 && fe_s3 && job_full);
	assign full = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1  <= mx;
			d_s1   <= dd;
			raw_s1 <= raw;
			x_s1   <= (pix.pos_x > XMAX) ? XMAX : pix.pos_x;
			y_s1   <= (pix.pos_y > YMAX) ? YMAX : pix.pos_y;
			fe_s1  <= pix.frame_end;
			sp_s2  <= sp;
			hp_s2  <= hp;
			mx_s2  <= mx_s1;
			x_s2   <= x_s1;
			y_s2   <= y_s1;
			fe_s2  <= fe_s1;
			red_s3 <= is_red;
			x_s3   <= x_s2;
			y_s3   <= y_s2;
			fe_s3  <= fe_s2;
		end
	end

	// accumulators
	logic [COUNT_W-1:0] pix_q, red_q, pix_n, red_n;
	logic [SUM_W-1:0] sx_q, sy_q, sx_n, sy_n;
	logic take_red;
	always_comb begin
		take_red = red_s3 && (red_q != COUNT_CAP);
		pix_n = (pix_q != COUNT_CAP) ? pix_q + 1'b1 : pix_q;
		red_n = take_red ? red_q + 1'b1 : red_q;
		sx_n  = take_red ? sx_q + SUM_W'(x_s3) : sx_q;
		sy_n  = take_red ? sy_q + SUM_W'(y_s3) : sy_q;
		job   = '{sum_x: sx_n, sum_y: sy_n, red_cnt: red_n, pix_cnt: pix_n};
		job_push = v_s3 && fe_s3 && en && (red_n != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q <= '0;
			red_q <= '0;
			sx_q  <= '0;
			sy_q  <= '0;
		end else if (v_s3 && en) begin
			if (fe_s3) begin
				pix_q <= '0;
				red_q <= '0;
				sx_q  <= '0;
				sy_q  <= '0;
			end else begin
				pix_q <= pix_n;
				red_q <= red_n;
				sx_q  <= sx_n;
				sy_q  <= sy_n;
			end
		end
	end

endmodule

@@ rtl/core/hsvcb_back.sv @@
// Back end: shared restoring divider for centroid x, y and coverage,
// plus the result register. Uses hsvcb_pkg.
module hsvcb_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  job_valid,
	input  hsvcb_pkg::job_t       job,
	output logic                  job_take,
	output logic                  empty,
	input  logic                  pop,
	output hsvcb_pkg::res_item_t  res
);
	import hsvcb_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_HOLD} state_t;

	state_t state_q;
	logic [1:0] phase_q;
	logic [3:0] step_q;
	logic [REM_W-1:0] rem_q, dsh_q, covn_q;
	logic [QUO_W-1:0] quo_q;
	logic [SUM_W-1:0] sy_q;
	logic [COUNT_W-1:0] red_q, pix_q;
	logic [CW-1:0] cx_q, cy_q;
	logic [13:0] cov_q;
	logic out_valid_q;
	res_item_t res_q;

	logic ge;
	logic [QUO_W-1:0] quo_n;
	assign ge    = rem_q >= dsh_q;
	assign quo_n = {quo_q[QUO_W-2:0], ge};

	assign job_take = (state_q == ST_IDLE) && job_valid;
	assign empty    = !out_valid_q;
	assign res      = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && out_valid_q && (state_q != ST_HOLD)) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						sy_q    <= job.sum_y;
						red_q   <= job.red_cnt;
						pix_q   <= job.pix_cnt;
						covn_q  <= REM_W'(job.red_cnt) * REM_W'(COV_SCALE);
						rem_q   <= REM_W'(job.sum_x);
						dsh_q   <= REM_W'({job.red_cnt, 13'b0});
						phase_q <= 2'd0;
						step_q  <= 4'(QUO_W - 1);
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					quo_q <= quo_n;
					rem_q <= ge ? rem_q - dsh_q : rem_q;
					dsh_q <= dsh_q >> 1;
					step_q <= step_q - 1'b1;
					if (step_q == '0) begin
						step_q <= 4'(QUO_W - 1);
						case (phase_q)
							2'd0: begin
								cx_q    <= quo_n[CW-1:0];
								rem_q   <= REM_W'(sy_q);
								dsh_q   <= REM_W'({red_q, 13'b0});
								phase_q <= 2'd1;
							end
							2'd1: begin
								cy_q    <= quo_n[CW-1:0];
								rem_q   <= covn_q;
								dsh_q   <= REM_W'({pix_q, 13'b0});
								phase_q <= 2'd2;
							end
							default: begin
								cov_q   <= quo_n;
								state_q <= ST_HOLD;
							end
						endcase
					end
				end
				ST_HOLD: begin
					if (!out_valid_q || pop) begin
						res_q       <= '{centroid_x: cx_q, centroid_y: cy_q, coverage: cov_q};
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_phase: assert property (@(posedge clk) disable iff (!arst_n) phase_q != 2'd3)
		else $error("divider phase out of range");
	a_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> {1'b0, rem_q} < {dsh_q, 1'b0})
		else $error("quotient overflow in divider");
	a_cov: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_HOLD |-> cov_q <= 14'(COV_SCALE))
		else $error("coverage above full scale");

endmodule

@@ rtl/core/hsv_color_blob_centroid.sv @@
// Pixel stream red-blob centroid and coverage, top level.
// Uses hsvcb_pkg, hsvcb_front, hsvcb_back.
//
// Takes one BGR pixel per cycle; full rises only when a frame-end pixel
// finds the two-entry job queue full. Pixels pass a three-stage HSV and
// threshold pipeline, then the accumulators. A frame with red pixels queues
// one job; the back end runs three 14-step divisions in one shared
// restoring divider, overlapping the next frame's pixels, and holds each
// result until the result register is free. Frames with no red pixels
// produce no result.
module hsv_color_blob_centroid (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  hsvcb_pkg::pix_item_t  pix,
	output logic                  empty,
	input  logic                  pop,
	output hsvcb_pkg::res_item_t  res,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [7:0]            cfg_data
);
	import hsvcb_pkg::*;

	logic job_push, job_full, job_take;
	job_t job_in;
	job_t slot_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;

	assign cfg_ready = 1'b1;
	assign job_full  = cnt_q == 2'd2;

	hsvcb_front u_front (
		.clk, .arst_n, .cfg_valid, .cfg_index, .cfg_data,
		.push, .full, .pix,
		.job_full, .job_push, .job(job_in)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (job_push) begin
				slot_q[wr_q] <= job_in;
				wr_q <= !wr_q;
			end
			if (job_take) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(job_push) - 2'(job_take);
		end
	end

	hsvcb_back u_back (
		.clk, .arst_n,
		.job_valid(cnt_q != 2'd0), .job(slot_q[rd_q]), .job_take,
		.empty, .pop, .res
	);

endmodule

@@ dv/hsv_color_blob_centroid_test.sv @@
// Testbench for hsv_color_blob_centroid: random and directed pixel frames,
// predicted centroid and coverage checked in order. Depends on hsvcb_pkg.
`timescale 1ns / 1ps

class blob_scoreboard;
	hsvcb_pkg::res_item_t pending[$];
	hsvcb_pkg::cfg_t cfg;
	logic [22:0] pix_cnt, red_cnt;
	logic [33:0] sum_x, sum_y;
	int errors;
	int results_seen;
	int frames_seen;

	function new();
		cfg = '{8'd10, 8'd170, 8'd180, 8'd255, 8'd100, 8'd255};
		pix_cnt = 0;
		red_cnt = 0;
		sum_x = 0;
		sum_y = 0;
		errors = 0;
		results_seen = 0;
		frames_seen = 0;
	endfunction

	function void set_reg(hsvcb_pkg::cfg_reg_t idx, logic [7:0] d);
		case (idx)
			hsvcb_pkg::REG_HUE_LOW_MAX:  cfg.hue_low_max = d;
			hsvcb_pkg::REG_HUE_HIGH_MIN: cfg.hue_high_min = d;
			hsvcb_pkg::REG_SAT_MIN:      cfg.sat_min = d;
			hsvcb_pkg::REG_SAT_MAX:      cfg.sat_max = d;
			hsvcb_pkg::REG_VAL_MIN:      cfg.val_min = d;
			default:                     cfg.val_max = d;
		endcase
	endfunction

	static function int recip(int num, int den);
		if (den <= 0)
			return 0;
		return (2 * num + den) / (2 * den);
	endfunction

	function bit pixel_is_red(hsvcb_pkg::pix_item_t p);
		int b, g, r, mx, mn, d, raw, hue, sat;
		b = p.blue;
		g = p.green;
		r = p.red;
		mx = b;
		mn = b;
		if (g > mx) mx = g;
		if (r > mx) mx = r;
		if (g < mn) mn = g;
		if (r < mn) mn = r;
		d = mx - mn;
		sat = (d * recip(255 * 4096, mx) + 2048) >>> 12;
		if (mx == r)
			raw = g - b;
		else if (mx == g)
			raw = b - r + 2 * d;
		else
			raw = r - g + 4 * d;
		hue = raw * recip(hsvcb_pkg::HUE_SPAN * 4096 / 6, d) + 2048 + (1 << 26);
		hue = (hue >>> 12) - (1 << 14);
		if (hue < 0)
			hue += hsvcb_pkg::HUE_SPAN;
		return sat >= cfg.sat_min && sat <= cfg.sat_max && mx >= cfg.val_min &&
			mx <= cfg.val_max && (hue <= cfg.hue_low_max ||
			(hue >= cfg.hue_high_min && hue <= hsvcb_pkg::HUE_SPAN));
	endfunction

	function void note_pixel(hsvcb_pkg::pix_item_t p);
		hsvcb_pkg::res_item_t e;
		if (pix_cnt != hsvcb_pkg::COUNT_CAP)
			pix_cnt++;
		if (pixel_is_red(p) && red_cnt != hsvcb_pkg::COUNT_CAP) begin
			red_cnt++;
			sum_x += p.pos_x;
			sum_y += p.pos_y;
		end
		if (p.frame_end) begin
			frames_seen++;
			if (red_cnt != 0) begin
				e.centroid_x = sum_x / red_cnt;
				e.centroid_y = sum_y / red_cnt;
				e.coverage = (64'(red_cnt) * 10000) / pix_cnt;
				pending.push_back(e);
			end
			pix_cnt = 0;
			red_cnt = 0;
			sum_x = 0;
			sum_y = 0;
		end
	endfunction

	function void check_result(hsvcb_pkg::res_item_t a);
		hsvcb_pkg::res_item_t e;
		results_seen++;
		if (pending.size() == 0) begin
			$error("unexpected result cx=%0d cy=%0d cov=%0d", a.centroid_x,
				a.centroid_y, a.coverage);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (a.centroid_x !== e.centroid_x) begin
			$error("centroid_x expected %0d actual %0d", e.centroid_x, a.centroid_x);
			errors++;
		end
		if (a.centroid_y !== e.centroid_y) begin
			$error("centroid_y expected %0d actual %0d", e.centroid_y, a.centroid_y);
			errors++;
		end
		if (a.coverage !== e.coverage) begin
			$error("coverage expected %0d actual %0d", e.coverage, a.coverage);
			errors++;
		end
	endfunction
endclass

module hsv_color_blob_centroid_test;
	import hsvcb_pkg::*;

	localparam int WATCHDOG = 20000;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	pix_item_t pix;
	logic empty;
	logic pop;
	res_item_t res;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [7:0] cfg_data;

	blob_scoreboard sb;
	bit quiet_tail;
	bit hold_sink;
	int idle_cycles;
	int pixels_sent;

	hsv_color_blob_centroid u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .pix(pix),
		.empty(empty), .pop(pop), .res(res), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		push = 0;
		pop = 0;
		pix = '0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		quiet_tail = 0;
		hold_sink = 0;
		pixels_sent = 0;
		sb = new();
		arst_n = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
	end

	// result side: random pop stalls, checks on accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				sb.check_result(res);
		end
	end

	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_sink) begin
				pop <= 0;
				repeat (400) @(posedge clk);
				hold_sink = 0;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 6);
				pop <= 0;
				repeat (gap) @(posedge clk);
			end else begin
				pop <= 1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [7:0] d);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		sb.set_reg(idx, d);
		@(posedge clk);
	endtask

	task automatic send_pixel(pix_item_t p);
		int gap;
		if (!quiet_tail && $urandom_range(0, 6) == 0) begin
			gap = $urandom_range(1, 6);
			push <= 0;
			repeat (gap) @(posedge clk);
		end
		push <= 1;
		pix <= p;
		do @(posedge clk); while (full);
		sb.note_pixel(p);
		pixels_sent++;
	endtask

	task automatic end_sending();
		push <= 0;
	endtask

	task automatic drain();
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic pix_item_t make_pixel(bit last, bit reddish);
		pix_item_t p;
		p.blue = $urandom;
		p.green = $urandom;
		p.red = $urandom;
		if (reddish) begin
			p.red = $urandom_range(150, 255);
			p.green = $urandom_range(0, 40);
			p.blue = $urandom_range(0, 40);
		end
		p.pos_x = ($urandom_range(0, 9) == 0) ? 11'($urandom) : 11'($urandom_range(0, 63));
		p.pos_y = ($urandom_range(0, 9) == 0) ? 11'($urandom) : 11'($urandom_range(0, 63));
		p.frame_end = last;
		return p;
	endfunction

	task automatic random_frame(int len);
		int k;
		for (k = 0; k < len; k++)
			send_pixel(make_pixel(k == len - 1, $urandom_range(0, 2) == 0));
	endtask

	task automatic random_config();
		write_reg(REG_HUE_LOW_MAX, $urandom_range(0, 180));
		write_reg(REG_HUE_HIGH_MIN, $urandom_range(0, 180));
		write_reg(REG_SAT_MIN, $urandom_range(0, 200));
		write_reg(REG_SAT_MAX, $urandom_range(100, 255));
		write_reg(REG_VAL_MIN, $urandom_range(0, 200));
		write_reg(REG_VAL_MAX, $urandom_range(100, 255));
	endtask

	initial begin
		int ph;
		@(posedge arst_n);
		@(posedge clk);
		// directed: extremes, gray, pure primaries, coordinate corners
		send_pixel('{8'd0, 8'd0, 8'd255, 11'd0, 11'd0, 1'b0});
		send_pixel('{8'd255, 8'd255, 8'd255, 11'd2047, 11'd2047, 1'b0});
		send_pixel('{8'd0, 8'd0, 8'd0, 11'd5, 11'd7, 1'b0});
		send_pixel('{8'd0, 8'd255, 8'd0, 11'd1, 11'd1, 1'b0});
		send_pixel('{8'd255, 8'd0, 8'd0, 11'd2, 11'd2, 1'b0});
		send_pixel('{8'd10, 8'd0, 8'd255, 11'd2047, 11'd0, 1'b0});
		send_pixel('{8'd0, 8'd20, 8'd200, 11'd0, 11'd2047, 1'b1});
		send_pixel('{8'd0, 8'd0, 8'd0, 11'd3, 11'd3, 1'b1});
		send_pixel('{8'd255, 8'd0, 8'd255, 11'd4, 11'd4, 1'b1});
		send_pixel('{8'd0, 8'd0, 8'd255, 11'd9, 11'd9, 1'b1});
		end_sending();
		drain();
		// all-pass and inverted bounds
		write_reg(REG_HUE_LOW_MAX, 8'd180);
		write_reg(REG_HUE_HIGH_MIN, 8'd0);
		write_reg(REG_SAT_MIN, 8'd0);
		write_reg(REG_SAT_MAX, 8'd255);
		write_reg(REG_VAL_MIN, 8'd0);
		write_reg(REG_VAL_MAX, 8'd255);
		random_frame(5);
		send_pixel('{8'd17, 8'd200, 8'd3, 11'd2047, 11'd2047, 1'b1});
		end_sending();
		drain();
		write_reg(REG_SAT_MIN, 8'd255);
		write_reg(REG_SAT_MAX, 8'd0);
		random_frame(4);
		end_sending();
		drain();
		write_reg(REG_HUE_LOW_MAX, 8'd0);
		write_reg(REG_HUE_HIGH_MIN, 8'd180);
		write_reg(REG_SAT_MIN, 8'd0);
		write_reg(REG_SAT_MAX, 8'd255);
		random_frame(3);
		end_sending();
		drain();
		for (ph = 0; ph < 6; ph++) begin
			if (ph == 5)
				write_reg(REG_VAL_MIN, 8'd0);
			else
				random_config();
			if (ph == 2)
				hold_sink = 1;
			if (ph == 5)
				quiet_tail = 1;
			while (pixels_sent < 210 * (ph + 1) + 30)
				random_frame($urandom_range(0, 3) == 0 ? 1 : $urandom_range(2, 12));
			end_sending();
			drain();
		end
		$display("Ran %0d pixels in %0d frames, %0d results checked, across 10 settings.",
			pixels_sent, sb.frames_seen, sb.results_seen);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
